// File: design/vlsag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector load/store address generator - shared definitions
// Operation and mode codes, the run command passed from the front end to the
// back end, and the index width mask helper.
// ----------------------------------------------------------------------------
package vlsag_pkg;

  // Index store geometry
  localparam int StoreDepth   = 32;
  localparam int IdxW         = $clog2(StoreDepth);
  localparam int CmdFifoDepth = 2;

  // Element / index width codes
  localparam logic [1:0] EwCode8  = 2'd0;
  localparam logic [1:0] EwCode16 = 2'd1;
  localparam logic [1:0] EwCode32 = 2'd2;

  typedef enum logic {
    OP_INDEX_WRITE = 1'b0,
    OP_START       = 1'b1
  } vlsag_op_e;

  typedef enum logic [1:0] {
    MODE_UNIT    = 2'd0,
    MODE_STRIDED = 2'd1,
    MODE_INDEXED = 2'd2
  } vlsag_mode_e;

  // One classified address run
  typedef struct packed {
    logic [63:0]           base;
    logic [63:0]           step;       // per-element offset increment
    logic [StoreDepth-1:0] active;     // elements that issue a request
    logic [3:0]            size;       // request size in bytes
    logic                  is_indexed;
    logic [1:0]            ew;         // clamped index width code
  } vlsag_cmd_t;

  // Keep the low index bits selected by the index width code
  function automatic logic [31:0] index_mask(logic [1:0] ew);
    logic [31:0] m;
    unique case (ew)
      EwCode8:  m = 32'h0000_00FF;
      EwCode16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// File: design/vlsag_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vlsag_ram #(
  parameter int Width = 32,
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/vlsag_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run command queue
// Short FIFO that decouples the classifying front end from the back end.
// ----------------------------------------------------------------------------
module vlsag_cmd_fifo
  import vlsag_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  vlsag_cmd_t push_data_i,
  output logic       full_o,
  output logic       empty_o,
  output logic       pop_valid_o,
  output vlsag_cmd_t pop_data_o,
  input  logic       pop_i
);

  localparam int PtrW = (CmdFifoDepth > 1) ? $clog2(CmdFifoDepth) : 1;
  localparam int CntW = $clog2(CmdFifoDepth + 1);

  vlsag_cmd_t        mem_q [CmdFifoDepth];
  logic [PtrW-1:0]   wptr_q, wptr_d;
  logic [PtrW-1:0]   rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(CmdFifoDepth));
  assign empty_o     = (cnt_q == '0);
  assign pop_valid_o = !empty_o;
  assign pop_data_o  = mem_q[rptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and occupancy update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(CmdFifoDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(CmdFifoDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/vlsag_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Accepts input items, writes index elements, classifies start items into run
// commands (active element vector, step, size) and queues those with an active element.
// ----------------------------------------------------------------------------
module vlsag_front
  import vlsag_pkg::*;
#(
  parameter int MaxElems = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [IdxW-1:0]       index_slot_i,
  input  logic [31:0]           index_value_i,
  input  logic [1:0]            mode_i,
  input  logic [1:0]            elem_width_code_i,
  input  logic [1:0]            data_width_code_i,
  input  logic [63:0]           base_address_i,
  input  logic signed [63:0]    stride_i,
  input  logic [31:0]           mask_bits_i,
  input  logic                  unmasked_i,
  input  logic [5:0]            start_index_i,
  input  logic [5:0]            length_i,
  // index store write
  output logic                  idx_wr_en_o,
  output logic [IdxW-1:0]       idx_wr_addr_o,
  output logic [31:0]           idx_wr_data_o,
  // run commands to the back end
  input  logic                  back_idle_i,
  output logic                  cmd_valid_o,
  output vlsag_cmd_t            cmd_o,
  input  logic                  cmd_ready_i
);

  localparam int Limit = (MaxElems < StoreDepth) ? MaxElems : StoreDepth;

  logic                  is_write;
  logic                  accept;
  logic                  fifo_full, fifo_empty;
  logic [1:0]            ew_c;
  logic [3:0]            ebytes;
  logic [5:0]            len_c;
  logic [StoreDepth-1:0] enables;
  logic [StoreDepth-1:0] in_range;
  vlsag_cmd_t            cmd;
  logic                  push;

  assign is_write = (vlsag_op_e'(operation_i) == OP_INDEX_WRITE);

  // Index writes wait until every queued run has read the store
  assign in_ready_o = is_write ? (fifo_empty && back_idle_i) : !fifo_full;
  assign accept     = in_valid_i && in_ready_o;

  assign idx_wr_en_o   = accept && is_write;
  assign idx_wr_addr_o = index_slot_i;
  assign idx_wr_data_o = index_value_i;

  // Width decode; code 3 behaves as 32 bits
  assign ew_c   = (elem_width_code_i > EwCode32) ? EwCode32 : elem_width_code_i;
  assign ebytes = 4'd1 << ew_c;
  assign len_c  = (length_i > 6'(Limit)) ? 6'(Limit) : length_i;

  // Active element vector
  always_comb begin
    enables = unmasked_i ? '1 : mask_bits_i[StoreDepth-1:0];
    for (int i = 0; i < StoreDepth; i++) begin
      in_range[i] = (6'(i) >= start_index_i) && (6'(i) < len_c);
    end
  end

  // Classify the run
  always_comb begin
    cmd.base       = base_address_i;
    cmd.size       = ebytes;
    cmd.is_indexed = 1'b0;
    cmd.ew         = ew_c;
    cmd.active     = enables & in_range;
    unique case (mode_i)
      MODE_UNIT: begin
        cmd.step = 64'(ebytes);
      end
      MODE_STRIDED: begin
        cmd.step = stride_i;
      end
      MODE_INDEXED: begin
        cmd.step       = '0;
        cmd.size       = 4'd1 << data_width_code_i;
        cmd.is_indexed = 1'b1;
      end
      default: begin
        cmd.step   = '0;
        cmd.active = '0;
      end
    endcase
  end

  // Runs with no active element produce nothing and are dropped here
  assign push = accept && !is_write && (cmd.active != '0);

  vlsag_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty),
    .pop_valid_o (cmd_valid_o),
    .pop_data_o  (cmd_o),
    .pop_i       (cmd_ready_i)
  );

endmodule

// File: design/vlsag_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Walks the elements of a run one per cycle, holding at an active element
// while the element stage is full, reads index elements for indexed runs,
// and forms the request address into the output register.
module vlsag_back
  import vlsag_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            addr_is_64_i,
  // run commands
  input  logic            cmd_valid_i,
  input  vlsag_cmd_t      cmd_i,
  output logic            cmd_ready_o,
  output logic            idle_o,
  // index store read
  output logic            idx_rd_en_o,
  output logic [IdxW-1:0] idx_rd_addr_o,
  input  logic [31:0]     idx_rd_data_i,
  // request channel
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [63:0]     address_o,
  output logic [3:0]      size_bytes_o,
  output logic [IdxW-1:0] element_index_o,
  output logic            last_o
);

  localparam logic [StoreDepth-1:0] OneHot0 = StoreDepth'(1);

  // Walk stage
  logic                  busy_q;
  logic [63:0]           base_q, step_q;
  logic [3:0]            size_q;
  logic                  is_idx_q;
  logic [1:0]            ew_q;
  logic [StoreDepth-1:0] rem_q, rem_next;
  logic [IdxW-1:0]       idx_q;
  logic [63:0]           off_q;
  logic                  hit, advance, take_cmd;

  // Element stage (index read in flight)
  logic                  b_valid_q;
  logic [63:0]           b_base_q, b_off_q;
  logic [3:0]            b_size_q;
  logic                  b_is_idx_q;
  logic [1:0]            b_ew_q;
  logic [IdxW-1:0]       b_idx_q;
  logic                  b_last_q;
  logic                  b_free, b_load;

  // Output register
  logic                  out_valid_q;
  logic [63:0]           addr_q;
  logic [3:0]            size_out_q;
  logic [IdxW-1:0]       elem_q;
  logic                  last_q;
  logic                  out_load;
  logic [63:0]           offset, sum;

  assign cmd_ready_o = !busy_q;
  assign idle_o      = !busy_q;
  assign take_cmd    = cmd_valid_i && !busy_q;

  assign hit      = rem_q[idx_q];
  assign rem_next = rem_q & ~(OneHot0 << idx_q);
  assign out_load = b_valid_q && (!out_valid_q || out_ready_i);
  assign b_free   = !b_valid_q || out_load;
  assign b_load   = busy_q && hit && b_free;
  assign advance  = busy_q && (!hit || b_free);

  assign idx_rd_en_o   = b_load;
  assign idx_rd_addr_o = idx_q;

  // Address formation and wrap
  assign offset = b_is_idx_q ? 64'(idx_rd_data_i & index_mask(b_ew_q)) : b_off_q;
  assign sum    = b_base_q + offset;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_cmd) begin
        busy_q <= 1'b1;
      end else if (advance && (rem_next == '0)) begin
        busy_q <= 1'b0;
      end
      if (b_load) begin
        b_valid_q <= 1'b1;
      end else if (out_load) begin
        b_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Walk registers
  always_ff @(posedge clk_i) begin
    if (take_cmd) begin
      base_q   <= cmd_i.base;
      step_q   <= cmd_i.step;
      size_q   <= cmd_i.size;
      is_idx_q <= cmd_i.is_indexed;
      ew_q     <= cmd_i.ew;
      rem_q    <= cmd_i.active;
      idx_q    <= '0;
      off_q    <= '0;
    end else if (advance) begin
      rem_q <= rem_next;
      idx_q <= idx_q + 1'b1;
      off_q <= off_q + step_q;
    end
  end

  // Element stage payload
  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_base_q   <= base_q;
      b_off_q    <= off_q;
      b_size_q   <= size_q;
      b_is_idx_q <= is_idx_q;
      b_ew_q     <= ew_q;
      b_idx_q    <= idx_q;
      b_last_q   <= (rem_next == '0);
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      addr_q     <= addr_is_64_i ? sum : {32'd0, sum[31:0]};
      size_out_q <= b_size_q;
      elem_q     <= b_idx_q;
      last_q     <= b_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign address_o       = addr_q;
  assign size_bytes_o    = size_out_q;
  assign element_index_o = elem_q;
  assign last_o          = last_q;

endmodule

// File: design/vector_load_store_address_gen_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector load/store address generator
// Per-element memory request generation for unit, strided and indexed runs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): operation 0 writes one index
//   element into the 32-entry index store; operation 1 starts a run over
//   elements start_index..length-1 (length capped at MaxElems and 32).
//   Output channel (out_valid_o/out_ready_i): one request per active element,
//   in rising element order, last_o set on the final one. Empty runs and
//   mode 3 produce no transfer.
//   cfg_we_i/cfg_wdata_i write address_is_64 (reset 1); write it only idle.
// Timing:
//   A run is queued the cycle it is accepted (two-entry command queue), and
//   the back end walks elements 0..last active one per cycle while the
//   element stage can take each active element. Each request passes from
//   the walk through the element stage into the output register. The next
//   queued run starts its walk once the previous walk has finished, while
//   that run's last requests may still be in flight. An index write waits
//   until the queue is empty and the walk has finished.
//   A stalled receiver holds the output register; the walk then stops at the
//   next active element while new runs keep queuing until the queue is full.
// Reset: control clears at once; index entries are undefined until written.
// ----------------------------------------------------------------------------
module vector_load_store_address_gen_core
  import vlsag_pkg::*;
#(
  parameter int MaxElems = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [4:0]         index_slot_i,
  input  logic [31:0]        index_value_i,
  input  logic [1:0]         mode_i,
  input  logic [1:0]         elem_width_code_i,
  input  logic [1:0]         data_width_code_i,
  input  logic [63:0]        base_address_i,
  input  logic signed [63:0] stride_i,
  input  logic [31:0]        mask_bits_i,
  input  logic               unmasked_i,
  input  logic [5:0]         start_index_i,
  input  logic [5:0]         length_i,
  // request channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [63:0]        address_o,
  output logic [3:0]         size_bytes_o,
  output logic [4:0]         element_index_o,
  output logic               last_o
);

  logic            addr_is_64_q;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [31:0]     wr_data;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [31:0]     rd_data;
  logic            cmd_valid, cmd_ready, back_idle;
  vlsag_cmd_t      cmd;

  // Address width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_is_64_q <= 1'b1;
    end else if (cfg_we_i) begin
      addr_is_64_q <= cfg_wdata_i;
    end
  end

  vlsag_front #(
    .MaxElems (MaxElems)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .index_slot_i      (index_slot_i),
    .index_value_i     (index_value_i),
    .mode_i            (mode_i),
    .elem_width_code_i (elem_width_code_i),
    .data_width_code_i (data_width_code_i),
    .base_address_i    (base_address_i),
    .stride_i          (stride_i),
    .mask_bits_i       (mask_bits_i),
    .unmasked_i        (unmasked_i),
    .start_index_i     (start_index_i),
    .length_i          (length_i),
    .idx_wr_en_o       (wr_en),
    .idx_wr_addr_o     (wr_addr),
    .idx_wr_data_o     (wr_data),
    .back_idle_i       (back_idle),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd),
    .cmd_ready_i       (cmd_ready)
  );

  // Index store
  vlsag_ram #(
    .Width (32),
    .Depth (StoreDepth)
  ) u_index_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  vlsag_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .addr_is_64_i    (addr_is_64_q),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_ready_o     (cmd_ready),
    .idle_o          (back_idle),
    .idx_rd_en_o     (rd_en),
    .idx_rd_addr_o   (rd_addr),
    .idx_rd_data_i   (rd_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .address_o       (address_o),
    .size_bytes_o    (size_bytes_o),
    .element_index_o (element_index_o),
    .last_o          (last_o)
  );

endmodule
